FILE: design/tsvd_pkg.sv
// Package for the tab-separated text deframer with backslash escapes.
// Holds the item types, the result kind and error codes, and the character constants.
// No dependencies.
package tsvd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_RECORD_END = 2'd2,
    KIND_ERROR      = 2'd3
  } kind_e;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic ERR_INCOMPLETE = 1'b0;
  localparam logic ERR_INVALID    = 1'b1;

  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   out_byte;
    logic [15:0]  field_length;
    logic [7:0]   field_index;
    logic [31:0]  record_number;
    logic         error_code;
  } out_item_t;

endpackage

FILE: design/tsvd_core.sv
// Decode step of the deframer: record, field and escape state plus the
// per-byte decision. Depends on tsvd_pkg.
module tsvd_core import tsvd_pkg::*; #(
  parameter longint unsigned FIELD_LEN_MAX   = 65535,
  parameter int unsigned     FIELD_INDEX_MAX = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      escape_enable_i,
  input  in_item_t  item_i,
  output logic      emit_o,
  output out_item_t result_o
);

  localparam int LEN_W  = $clog2(FIELD_LEN_MAX + 64'd1);
  localparam int IDX_W  = $clog2(FIELD_INDEX_MAX + 1);
  localparam int LEN_XW = (LEN_W > 16) ? LEN_W : 16;
  localparam int IDX_XW = (IDX_W > 8) ? IDX_W : 8;
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(FIELD_LEN_MAX);
  localparam logic [IDX_W-1:0] IdxMax = IDX_W'(FIELD_INDEX_MAX);

  logic             in_rec_q, in_rec_d;
  logic             esc_q, esc_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [31:0]      rec_q, rec_d;

  logic             start;
  logic [LEN_W-1:0] len_v;
  logic [IDX_W-1:0] idx_v;
  logic [31:0]      rec_v;
  logic [LEN_W-1:0] len_inc;
  logic [LEN_XW-1:0] len_ext;
  logic [IDX_XW-1:0] idx_ext;
  logic             data_hit;
  logic [7:0]       data_val;

  assign start   = (item_i.op == OP_DATA) && !in_rec_q;
  assign len_v   = start ? '0 : len_q;
  assign idx_v   = start ? '0 : idx_q;
  assign rec_v   = start ? rec_q + 32'd1 : rec_q;
  assign len_inc = (len_v < LenMax) ? len_v + LEN_W'(1) : len_v;
  assign len_ext = LEN_XW'(len_v);
  assign idx_ext = IDX_XW'(idx_v);

  always_comb begin
    in_rec_d = in_rec_q;
    esc_d    = esc_q;
    len_d    = len_q;
    idx_d    = idx_q;
    rec_d    = rec_q;
    emit_o   = 1'b0;
    data_hit = 1'b0;
    data_val = item_i.data_byte;
    result_o = '0;
    result_o.field_index   = idx_ext[7:0];
    result_o.record_number = rec_v;

    if (item_i.op == OP_END) begin
      if (in_rec_q) begin
        in_rec_d = 1'b0;
        emit_o   = 1'b1;
        if (esc_q) begin
          esc_d               = 1'b0;
          result_o.kind       = KIND_ERROR;
          result_o.error_code = ERR_INCOMPLETE;
        end else begin
          result_o.kind         = KIND_RECORD_END;
          result_o.field_length = len_ext[15:0];
        end
      end
    end else begin
      in_rec_d = 1'b1;
      rec_d    = rec_v;
      len_d    = len_v;
      idx_d    = idx_v;
      if (esc_q) begin
        esc_d = 1'b0;
        unique case (item_i.data_byte)
          CH_N:         begin data_hit = 1'b1; data_val = CH_LF;        end
          CH_T:         begin data_hit = 1'b1; data_val = CH_TAB;       end
          CH_R:         begin data_hit = 1'b1; data_val = CH_CR;        end
          CH_BACKSLASH: begin data_hit = 1'b1; data_val = CH_BACKSLASH; end
          default: begin
            emit_o              = 1'b1;
            result_o.kind       = KIND_ERROR;
            result_o.error_code = ERR_INVALID;
          end
        endcase
      end else begin
        unique case (item_i.data_byte)
          CH_BACKSLASH: begin
            if (escape_enable_i) begin
              esc_d = 1'b1;
            end else begin
              data_hit = 1'b1;
            end
          end
          CH_CR: begin
          end
          CH_TAB: begin
            emit_o                = 1'b1;
            result_o.kind         = KIND_FIELD_END;
            result_o.field_length = len_ext[15:0];
            len_d                 = '0;
            idx_d                 = (idx_v < IdxMax) ? idx_v + IDX_W'(1) : idx_v;
          end
          CH_LF: begin
            emit_o                = 1'b1;
            result_o.kind         = KIND_RECORD_END;
            result_o.field_length = len_ext[15:0];
            in_rec_d              = 1'b0;
          end
          default: begin
            data_hit = 1'b1;
          end
        endcase
      end
      if (data_hit) begin
        emit_o            = 1'b1;
        result_o.kind     = KIND_DATA;
        result_o.out_byte = data_val;
        len_d             = len_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rec_q <= 1'b0;
      esc_q    <= 1'b0;
      len_q    <= '0;
      idx_q    <= '0;
      rec_q    <= '0;
    end else if (step_i) begin
      in_rec_q <= in_rec_d;
      esc_q    <= esc_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      rec_q    <= rec_d;
    end
  end

endmodule

FILE: design/tsv_escape_field_deframer.sv
// Top level of the tab-separated text deframer with backslash escapes.
// Input register, tsvd_core decode step and result register. Depends on tsvd_pkg, tsvd_core.
//
// One byte (or end-of-input mark) is taken per transfer, one per clock cycle when the
// result side does not stall. A transfer is registered in the input register, decoded
// against the record and escape state, and its result (if any) is loaded into the result
// register once the result side does not stall. The state update in the decode step
// sets the rate of one byte per cycle while the result side does not stall. Tab ends a
// field, newline ends field and record, carriage return is dropped; with escape_enable set,
// backslash-n/t/r/backslash decode to LF, TAB, CR or backslash; any other escape yields an
// error result. An escape left open at end of input yields an incomplete-escape error.
// Write the escape_enable register only while no transfer is in flight.
module tsv_escape_field_deframer import tsvd_pkg::*; #(
  parameter longint unsigned FIELD_LEN_MAX   = 65535,
  parameter int unsigned     FIELD_INDEX_MAX = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      esc_en_q;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      adv;
  logic      step;
  logic      emit;
  out_item_t result;

  assign adv        = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;

  tsvd_core #(
    .FIELD_LEN_MAX  (FIELD_LEN_MAX),
    .FIELD_INDEX_MAX(FIELD_INDEX_MAX)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .escape_enable_i(esc_en_q),
    .item_i         (in_item_q),
    .emit_o         (emit),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_en_q    <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        esc_en_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= step && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (step && emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: design/tsvd_checker.sv
// Port-level checks for the deframer, attached to the top level by bind.
// Depends on tsvd_pkg and tsv_escape_field_deframer.
module tsvd_port_checks import tsvd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // input side only backs up when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_DATA |->
      out_item_o.field_length == 16'd0 && out_item_o.error_code == 1'b0)
    else $error("data result carries field length or error code");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != KIND_ERROR |-> out_item_o.error_code == 1'b0)
    else $error("error code set on non-error result");

  a_ctl_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != KIND_DATA |-> out_item_o.out_byte == 8'd0)
    else $error("byte set on non-data result");

endmodule

bind tsv_escape_field_deframer tsvd_port_checks u_tsvd_port_checks (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
